### design/assert_macros.svh
// Assertion macros shared by the point-in-polygon design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property at every rising clock edge outside reset.
`define PIP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define PIP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PIP_ASSERT(lbl, clk, rst_n, prop, msg)
`define PIP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### design/pip_pkg.sv
// Shared type, constant and helper function of the point-in-polygon test.
package pip_pkg;

  // Depth of the queue between the front and the back; a power of two.
  localparam int unsigned QUEUE_DEPTH = 4;

  // One result transaction.
  typedef struct packed {
    logic inside_res;
    logic in_box;
  } res_t;

  // Width of one queue entry: point, start vertex, four differences,
  // the straddle flag and the last-edge mark.
  function automatic int unsigned entry_width(input int unsigned coord_w);
    return 4 * coord_w + 4 * (coord_w + 1) + 2;
  endfunction

endpackage

### design/pip_if.sv
// Channel interfaces of the point-in-polygon test.

// Edge transactions into the block.
interface pip_in_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] edge_start_x;
  logic signed [COORD_WIDTH-1:0] edge_start_y;
  logic signed [COORD_WIDTH-1:0] edge_end_x;
  logic signed [COORD_WIDTH-1:0] edge_end_y;
  logic                          last_edge;

  modport source (
    output valid, point_x, point_y, edge_start_x, edge_start_y, edge_end_x, edge_end_y,
           last_edge,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, edge_start_x, edge_start_y, edge_end_x, edge_end_y,
           last_edge,
    output ready
  );
endinterface

// Result transactions out of the block.
interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic in_box;

  modport source (output valid, inside_res, in_box, input ready);
  modport sink (input valid, inside_res, in_box, output ready);
endinterface

// Generic internal stream between the front, the queue and the back.
interface pip_stream_if #(
  parameter int unsigned WIDTH = 8
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### design/pip_front.sv
// Front stage: accepts edges, forms the differences and the straddle flag.
module pip_front #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  pip_in_if.sink         in_i,
  pip_stream_if.source   ent_o
);
  import pip_pkg::*;

  localparam int unsigned W       = COORD_WIDTH;
  localparam int unsigned ENTRY_W = entry_width(COORD_WIDTH);

  logic signed [W:0]    dx, dy, qx, qy;
  logic                 straddle;
  logic                 ent_valid_q, ent_valid_d;
  logic [ENTRY_W-1:0]   ent_data_q;
  logic                 in_fire;

  // Differences are one bit wider than the coordinates so they never overflow.
  assign dx = $signed({in_i.edge_end_x[W-1], in_i.edge_end_x})
            - $signed({in_i.edge_start_x[W-1], in_i.edge_start_x});
  assign dy = $signed({in_i.edge_end_y[W-1], in_i.edge_end_y})
            - $signed({in_i.edge_start_y[W-1], in_i.edge_start_y});
  assign qx = $signed({in_i.point_x[W-1], in_i.point_x})
            - $signed({in_i.edge_start_x[W-1], in_i.edge_start_x});
  assign qy = $signed({in_i.point_y[W-1], in_i.point_y})
            - $signed({in_i.edge_start_y[W-1], in_i.edge_start_y});

  // One endpoint strictly above the point's y and the other not.
  assign straddle = (in_i.edge_start_y > in_i.point_y) != (in_i.edge_end_y > in_i.point_y);

  assign in_i.ready = !ent_valid_q || ent_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    ent_valid_d = ent_valid_q;
    if (in_i.ready) begin
      ent_valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
    end else begin
      ent_valid_q <= ent_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ent_data_q <= {in_i.point_x, in_i.point_y, in_i.edge_start_x, in_i.edge_start_y,
                     dx, dy, qx, qy, straddle, in_i.last_edge};
    end
  end

  assign ent_o.valid = ent_valid_q;
  assign ent_o.data  = ent_data_q;

endmodule

### design/pip_queue.sv
// Short queue that decouples the front from the back.
`include "assert_macros.svh"

module pip_queue #(
  parameter int unsigned DATA_WIDTH = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pip_stream_if.sink    push_i,
  pip_stream_if.source  pop_o
);
  import pip_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_WIDTH-1:0] slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  push_fire, pop_fire;

  assign push_i.ready = count_q != CNT_W'(QUEUE_DEPTH);
  assign pop_o.valid  = count_q != '0;
  assign pop_o.data   = slot_q[rd_ptr_q];

  assign push_fire = push_i.valid && push_i.ready;
  assign pop_fire  = pop_o.valid && pop_o.ready;

  // Pointers wrap on their own since the depth is a power of two.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_fire) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
    end
    if (pop_fire) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
    if (push_fire && !pop_fire) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_fire && !push_fire) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      slot_q[wr_ptr_q] <= push_i.data;
    end
  end

  `PIP_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CNT_W'(QUEUE_DEPTH), "queue count exceeds depth")
  `PIP_ASSERT(a_ptr_count, clk_i, rst_ni, (wr_ptr_q - rd_ptr_q) == count_q[PTR_W-1:0], "queue pointers disagree with count")
  `PIP_ASSERT(a_count_inc, clk_i, rst_ni, (push_fire && !pop_fire) |=> count_q == $past(count_q) + CNT_W'(1), "queue count did not grow on push")

endmodule

### design/pip_back.sv
// Back stages: cross products, crossing parity, bounding box and result register.
`include "assert_macros.svh"

module pip_back #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pip_stream_if.sink    ent_i,
  pip_out_if.source     out_o
);
  import pip_pkg::*;

  localparam int unsigned W       = COORD_WIDTH;
  localparam int unsigned PROD_W  = 2 * (W + 1);
  localparam int unsigned ENTRY_W = entry_width(COORD_WIDTH);

  // Queue entry fields.
  logic signed [W-1:0] e_px, e_py, e_sx, e_sy;
  logic signed [W:0]   e_dx, e_dy, e_qx, e_qy;
  logic                e_straddle, e_last;
  logic [ENTRY_W-1:0]  e_data;

  // Multiply stage.
  logic signed [PROD_W-1:0] lhs, rhs;
  logic                     m_valid_q;
  logic signed [PROD_W-1:0] m_lhs_q, m_rhs_q;
  logic signed [W-1:0]      m_px_q, m_py_q, m_sx_q, m_sy_q;
  logic                     m_dy_pos_q, m_straddle_q, m_last_q;
  logic                     m_ready, m_adv, out_free;

  // Accumulation state.
  logic                parity_q, first_q;
  logic signed [W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic signed [W-1:0] min_x_d, max_x_d, min_y_d, max_y_d;
  logic                right, parity_d, inb;

  // Result register.
  logic out_valid_q;
  res_t out_res_q;

  assign e_data = ent_i.data;
  assign {e_px, e_py, e_sx, e_sy, e_dx, e_dy, e_qx, e_qy, e_straddle, e_last} = e_data;

  // The crossing x lies right of the point when dx*qy > qx*dy for dy above zero,
  // and with the comparison reversed otherwise.
  assign lhs = e_dx * e_qy;
  assign rhs = e_qx * e_dy;

  assign out_free    = !out_valid_q || out_o.ready;
  assign m_adv       = m_valid_q && (!m_last_q || out_free);
  assign m_ready     = !m_valid_q || m_adv;
  assign ent_i.ready = m_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (m_ready) begin
      m_valid_q <= ent_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_ready && ent_i.valid) begin
      m_lhs_q      <= lhs;
      m_rhs_q      <= rhs;
      m_px_q       <= e_px;
      m_py_q       <= e_py;
      m_sx_q       <= e_sx;
      m_sy_q       <= e_sy;
      m_dy_pos_q   <= !e_dy[W] && (e_dy != '0);
      m_straddle_q <= e_straddle;
      m_last_q     <= e_last;
    end
  end

  always_comb begin
    right    = m_dy_pos_q ? (m_lhs_q > m_rhs_q) : (m_lhs_q < m_rhs_q);
    parity_d = parity_q ^ (m_straddle_q && right);
    if (first_q) begin
      min_x_d = m_sx_q;
      max_x_d = m_sx_q;
      min_y_d = m_sy_q;
      max_y_d = m_sy_q;
    end else begin
      min_x_d = (m_sx_q < min_x_q) ? m_sx_q : min_x_q;
      max_x_d = (m_sx_q > max_x_q) ? m_sx_q : max_x_q;
      min_y_d = (m_sy_q < min_y_q) ? m_sy_q : min_y_q;
      max_y_d = (m_sy_q > max_y_q) ? m_sy_q : max_y_q;
    end
    inb = (m_px_q >= min_x_d) && (m_px_q <= max_x_d)
       && (m_py_q >= min_y_d) && (m_py_q <= max_y_d);
  end

  // The last edge returns the accumulation to its starting state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= 1'b0;
      first_q  <= 1'b1;
    end else if (m_adv) begin
      parity_q <= m_last_q ? 1'b0 : parity_d;
      first_q  <= m_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_adv) begin
      min_x_q <= min_x_d;
      max_x_q <= max_x_d;
      min_y_q <= min_y_d;
      max_y_q <= max_y_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (m_adv && m_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_adv && m_last_q) begin
      out_res_q.inside_res <= inb && parity_d;
      out_res_q.in_box     <= inb;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.inside_res = out_res_q.inside_res;
  assign out_o.in_box     = out_res_q.in_box;

  `PIP_ASSERT(a_out_from_last, clk_i, rst_ni, $rose(out_valid_q) |-> $past(m_adv && m_last_q), "result appeared without a last edge")
  `PIP_ASSERT(a_clear_after_last, clk_i, rst_ni, (m_adv && m_last_q) |=> (first_q && !parity_q), "state not cleared after last edge")
  `PIP_ASSERT(a_stage_hold, clk_i, rst_ni, (m_valid_q && !m_adv) |=> (m_valid_q && $stable(m_lhs_q) && $stable(m_last_q)), "multiply stage lost a stalled edge")

endmodule

### design/point_in_polygon_test.sv
// Top level of the even-odd point-in-polygon test.
//
// Each input transaction is one polygon edge together with the query point and a
// last-edge mark; the block takes one edge per clock cycle, sustained while the
// output does not stall, limited by the single multiply stage that forms both cross
// products of an edge. A result transaction (inside_res, in_box) is issued only for
// the last edge of a polygon and passes through the front register, the four-entry
// queue, the multiply stage and the result register, which is loaded in the same
// cycle that the edge is folded into the parity and the bounding box. While a result
// waits at the output, edges that are not last keep flowing through the back; only
// the next last edge stalls in the multiply stage, and the front then keeps taking
// edges until the queue and the front register are full. Coordinates are signed
// COORD_WIDTH-bit fixed point; the crossing test is exact and needs no division.
module point_in_polygon_test #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pip_in_if.sink     in_i,
  pip_out_if.source  out_o
);
  import pip_pkg::*;

  localparam int unsigned ENTRY_W = entry_width(COORD_WIDTH);

  pip_stream_if #(.WIDTH(ENTRY_W)) front_ch ();
  pip_stream_if #(.WIDTH(ENTRY_W)) back_ch ();

  pip_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .ent_o (front_ch)
  );

  pip_queue #(
    .DATA_WIDTH(ENTRY_W)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(front_ch),
    .pop_o (back_ch)
  );

  pip_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ent_i (back_ch),
    .out_o (out_o)
  );

endmodule
